>>> hdl/bif_pkg.sv
// Shared types and constants of the bilateral image filter.
// No dependencies; every module of the filter imports this package.
`timescale 1ns / 1ps
`default_nettype none
package bif_pkg;

   localparam int MAX_RADIUS  = 3;
   localparam int MAX_WIDTH   = 1024;
   localparam int WEIGHT_BITS = 16;

   localparam int NLINES      = 2 * MAX_RADIUS + 1;
   localparam int NSPATIAL    = NLINES * NLINES;
   localparam int NCH         = 3;
   localparam int CH_W        = 8;
   localparam int PIX_W       = NCH * CH_W;
   localparam int RANGE_DEPTH = 1 << CH_W;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int SLOT_W      = $clog2(NLINES);
   localparam int TAP_W       = $clog2(NLINES);
   localparam int SIDX_W      = $clog2(NSPATIAL);
   localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
   localparam int WIDTH_W     = 11;
   localparam int ROW_W       = 13;
   localparam int WT_W        = 2 * WEIGHT_BITS;
   localparam int WSUM_W      = WT_W + $clog2(NSPATIAL);
   localparam int PSUM_W      = WSUM_W + CH_W;
   localparam int PEND_W      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
   localparam int LAG_W       = WIDTH_W + RAD_W + 1;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int QCNT_W      = $clog2(CH_W + 1);

   // Transaction function codes.
   localparam logic [1:0] FUNC_PIXEL   = 2'd0;
   localparam logic [1:0] FUNC_FLUSH   = 2'd1;
   localparam logic [1:0] FUNC_RANGE   = 2'd2;
   localparam logic [1:0] FUNC_SPATIAL = 2'd3;

   // Weight modes.
   localparam logic [1:0] MODE_BILATERAL = 2'd0;
   localparam logic [1:0] MODE_SPATIAL   = 2'd1;
   localparam logic [1:0] MODE_RANGE     = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_MODE  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_GRAY_MODE    = CSR_IDX_W'(4);

   typedef struct packed {
      logic                   pix_we;
      logic [SLOT_W-1:0]      pix_slot;
      logic [COL_W-1:0]       pix_col;
      logic [PIX_W-1:0]       pix_data;
      logic                   rng_we;
      logic                   spa_we;
      logic [CH_W-1:0]        w_idx;
      logic [WEIGHT_BITS-1:0] w_val;
      logic [COL_W-1:0]       rd_col;
      logic                   step_valid;
      logic [TAP_W-1:0]       step_tap;
      logic                   acc_clear;
      logic [SLOT_W-1:0]      job_slot;
      logic [RAD_W-1:0]       radius;
      logic [1:0]             weight_mode;
      logic [PIX_W-1:0]       center;
   } lane_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0]             line_q;
      logic [NCH-1:0][PSUM_W-1:0]   psum;
      logic [NCH-1:0][WSUM_W-1:0]   wsum;
   } lane_result_type;

   typedef struct packed {
      logic                       done;
      logic [NCH-1:0][CH_W-1:0]   quot;
      logic [NCH-1:0]             wzero;
   } merge_result_type;

endpackage
`default_nettype wire

>>> hdl/bif_lane.sv
// One window-row lane: a line buffer, copies of the weight tables and a
// weighted accumulator per channel. Depends on bif_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bif_lane import bif_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [SLOT_W-1:0] lane_id,
   input  lane_ctrl_type   ctrl,
   output lane_result_type result
);

   logic [PIX_W-1:0]       line_mem [MAX_WIDTH];
   logic [PIX_W-1:0]       line_q_ff;
   logic [WEIGHT_BITS-1:0] spa_mem [NSPATIAL];
   logic [WEIGHT_BITS-1:0] spa_q_ff;
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [TAP_W-1:0]       tap1_ff;
   logic [SLOT_W:0]        dist_raw;
   logic [SLOT_W-1:0]      row_dist;
   logic [SLOT_W-1:0]      back;
   logic                   active;
   logic [TAP_W-1:0]       row_pos;
   logic [TAP_W-1:0]       span;
   logic [SIDX_W-1:0]      sidx;

   always_ff @(posedge clock) begin
      if (ctrl.pix_we && ctrl.pix_slot == lane_id) begin
         line_mem[ctrl.pix_col] <= ctrl.pix_data;
      end
      line_q_ff <= line_mem[ctrl.rd_col];
      if (ctrl.spa_we && ctrl.w_idx < NSPATIAL) begin
         spa_mem[ctrl.w_idx[SIDX_W-1:0]] <= ctrl.w_val;
      end
      spa_q_ff <= spa_mem[sidx];
      tap1_ff  <= ctrl.step_tap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.step_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Which window row this line holds, relative to the center line.
   always_comb begin
      dist_raw = {1'b0, lane_id} + (SLOT_W+1)'(NLINES) - {1'b0, ctrl.job_slot};
      if (dist_raw >= (SLOT_W+1)'(NLINES)) begin
         row_dist = SLOT_W'(dist_raw - (SLOT_W+1)'(NLINES));
      end else begin
         row_dist = dist_raw[SLOT_W-1:0];
      end
      back = SLOT_W'(NLINES) - row_dist;
      if (row_dist <= SLOT_W'(MAX_RADIUS)) begin
         active  = row_dist <= SLOT_W'(ctrl.radius);
         row_pos = TAP_W'(ctrl.radius) + TAP_W'(row_dist);
      end else begin
         active  = back <= SLOT_W'(ctrl.radius);
         row_pos = TAP_W'(ctrl.radius) - TAP_W'(back);
      end
      span = TAP_W'({ctrl.radius, 1'b1});
      sidx = SIDX_W'(row_pos) * SIDX_W'(span) + SIDX_W'(tap1_ff);
   end

   assign result.line_q = line_q_ff;

   for (genvar c = 0; c < NCH; c++) begin : g_ch
      logic [WEIGHT_BITS-1:0]   rng_mem [RANGE_DEPTH];
      logic [WEIGHT_BITS-1:0]   rng_q_ff;
      logic [CH_W-1:0]          nv, cv, diff;
      logic [CH_W-1:0]          nv2_ff, nv3_ff;
      logic [WT_W-1:0]          wt_in, wt_ff;
      logic [CH_W+WT_W-1:0]     prod;
      logic [PSUM_W-1:0]        psum_ff;
      logic [WSUM_W-1:0]        wsum_ff;

      always_comb begin
         nv   = line_q_ff[c*CH_W +: CH_W];
         cv   = ctrl.center[c*CH_W +: CH_W];
         diff = (nv > cv) ? nv - cv : cv - nv;
         case (ctrl.weight_mode)
            MODE_SPATIAL:   wt_in = WT_W'(spa_q_ff);
            MODE_RANGE:     wt_in = WT_W'(rng_q_ff);
            MODE_BILATERAL: wt_in = spa_q_ff * rng_q_ff;
            default:        wt_in = spa_q_ff * rng_q_ff;
         endcase
         prod = nv3_ff * wt_ff;
      end

      always_ff @(posedge clock) begin
         if (ctrl.rng_we) begin
            rng_mem[ctrl.w_idx] <= ctrl.w_val;
         end
         rng_q_ff <= rng_mem[diff];
         nv2_ff   <= nv;
         wt_ff    <= wt_in;
         nv3_ff   <= nv2_ff;
         if (ctrl.acc_clear) begin
            psum_ff <= '0;
            wsum_ff <= '0;
         end else if (s3_valid_ff && active) begin
            psum_ff <= psum_ff + PSUM_W'(prod);
            wsum_ff <= wsum_ff + WSUM_W'(wt_ff);
         end
      end

      assign result.psum[c] = psum_ff;
      assign result.wsum[c] = wsum_ff;
   end

endmodule
`default_nettype wire

>>> hdl/bif_merge.sv
// Merging stage: adds the lane sums and divides per channel, one quotient
// bit per cycle. Depends on bif_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bif_merge import bif_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lane_result_type  lane_res [NLINES],
   output merge_result_type result
);

   typedef enum logic [3:0] {
      M_IDLE = 4'b0001,
      M_SUM  = 4'b0010,
      M_PREP = 4'b0100,
      M_DIV  = 4'b1000
   } mstate_type;

   mstate_type          state_ff;
   logic [SLOT_W-1:0]   lcnt_ff;
   logic [QCNT_W-1:0]   kcnt_ff;
   logic                done_ff;
   logic [PSUM_W-1:0]   psum_tot_ff [NCH];
   logic [WSUM_W-1:0]   wsum_tot_ff [NCH];
   logic [PSUM_W-1:0]   rem_ff [NCH];
   logic [PSUM_W-1:0]   div_ff [NCH];
   logic [CH_W:0]       quot_ff [NCH];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         lcnt_ff  <= '0;
         kcnt_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  state_ff <= M_SUM;
                  lcnt_ff  <= '0;
               end
            end
            M_SUM: begin
               lcnt_ff <= lcnt_ff + SLOT_W'(1);
               if (lcnt_ff == SLOT_W'(NLINES - 1)) begin
                  state_ff <= M_PREP;
               end
            end
            M_PREP: begin
               kcnt_ff  <= QCNT_W'(CH_W);
               state_ff <= M_DIV;
            end
            M_DIV: begin
               kcnt_ff <= kcnt_ff - QCNT_W'(1);
               if (kcnt_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= M_IDLE;
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NCH; c++) begin
         if (state_ff == M_IDLE && start) begin
            psum_tot_ff[c] <= '0;
            wsum_tot_ff[c] <= '0;
         end else if (state_ff == M_SUM) begin
            psum_tot_ff[c] <= psum_tot_ff[c] + lane_res[lcnt_ff].psum[c];
            wsum_tot_ff[c] <= wsum_tot_ff[c] + lane_res[lcnt_ff].wsum[c];
         end
         if (state_ff == M_PREP) begin
            rem_ff[c]  <= psum_tot_ff[c];
            div_ff[c]  <= {wsum_tot_ff[c], CH_W'(0)};
            quot_ff[c] <= '0;
         end else if (state_ff == M_DIV) begin
            if (rem_ff[c] >= div_ff[c]) begin
               rem_ff[c] <= rem_ff[c] - div_ff[c];
            end
            quot_ff[c] <= {quot_ff[c][CH_W-1:0], rem_ff[c] >= div_ff[c]};
            div_ff[c]  <= div_ff[c] >> 1;
         end
      end
   end

   always_comb begin
      result.done = done_ff;
      for (int c = 0; c < NCH; c++) begin
         result.quot[c]  = quot_ff[c][CH_W] ? '1 : quot_ff[c][CH_W-1:0];
         result.wzero[c] = wsum_tot_ff[c] == '0;
      end
   end

endmodule
`default_nettype wire

>>> hdl/bilateral_image_filter_unit.sv
// Bilateral image filter, top level. Uses bif_pkg, bif_lane and bif_merge.
// Weight writes, flushes and pixels without a result are taken at once; a
// request with a result holds off further requests until it is in the output
// register, a filtered one after the lane column sweep and the 9-step divider.
// Latency in the stream: results trail the input by radius*width+radius pixels.
// Reset (synchronous) clears counters, control and configuration; line stores
// and weight tables keep no reset and are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module bilateral_image_filter_unit import bif_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [CH_W-1:0]        req_pixel_ch0,
   input  logic [CH_W-1:0]        req_pixel_ch1,
   input  logic [CH_W-1:0]        req_pixel_ch2,
   input  logic [7:0]             req_weight_index,
   input  logic [15:0]            req_weight_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CH_W-1:0]        rsp_out_ch0,
   output logic [CH_W-1:0]        rsp_out_ch1,
   output logic [CH_W-1:0]        rsp_out_ch2,
   output logic                   rsp_is_border,
   output logic                   rsp_frame_end,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PIPE_DEPTH = 4;
   localparam int DRAIN_W    = $clog2(PIPE_DEPTH);

   // Control sequence for one result: the center pixel is read first, then, for a
   // filtered result, the lanes sweep the window columns, the lane pipelines drain
   // and the merge stage sums and divides; the result is parked in the output register.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CENTER = 7'b0000010,
      ST_CWAIT  = 7'b0000100,
      ST_SWEEP  = 7'b0001000,
      ST_DRAIN  = 7'b0010000,
      ST_MERGE  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // Configuration registers.
   logic [WIDTH_W-1:0] cfg_width_ff;
   logic [ROW_W-1:0]   cfg_height_ff;
   logic [1:0]         cfg_radius_ff;
   logic [1:0]         cfg_mode_ff;
   logic               cfg_gray_ff;

   state_type          state_ff, state_in;
   logic [COL_W-1:0]   in_col_ff, in_col_in;
   logic [ROW_W-1:0]   in_row_ff, in_row_in;
   logic [SLOT_W-1:0]  in_slot_ff, in_slot_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [ROW_W-1:0]   out_row_ff, out_row_in;
   logic [SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [COL_W-1:0]   job_col_ff, job_col_in;
   logic [SLOT_W-1:0]  job_slot_ff, job_slot_in;
   logic               job_border_ff, job_border_in;
   logic               job_fend_ff, job_fend_in;
   logic [PIX_W-1:0]   center_ff, center_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic [NCH-1:0][CH_W-1:0] res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NCH-1:0][CH_W-1:0] rsp_ch_ff;
   logic               rsp_border_ff, rsp_fend_ff;

   logic [WIDTH_W-1:0] w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic [RAD_W-1:0]   r_eff;
   logic [TAP_W-1:0]   span_m1;
   logic [LAG_W-1:0]   lag;
   logic [PEND_W-1:0]  pend_plus;
   logic               accept, do_emit, load_rsp, merge_start;
   logic               in_col_last, in_row_last, out_col_last, out_row_last;
   logic               out_border;
   logic [PIX_W-1:0]   center_mux;

   lane_ctrl_type      lane_ctrl;
   lane_result_type    lane_res [NLINES];
   merge_result_type   merge_res;

   // A write to an index beyond the register list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= WIDTH_W'(1024);
         cfg_height_ff <= ROW_W'(1024);
         cfg_radius_ff <= 2'd1;
         cfg_mode_ff   <= MODE_BILATERAL;
         cfg_gray_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  cfg_width_ff  <= csr_wdata[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height_ff <= csr_wdata[ROW_W-1:0];
            REG_RADIUS:       cfg_radius_ff <= csr_wdata[1:0];
            REG_WEIGHT_MODE:  cfg_mode_ff   <= csr_wdata[1:0];
            REG_GRAY_MODE:    cfg_gray_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective frame geometry: a zero width or height acts as one, and widths
   // above the line buffer size are clipped to it.
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (cfg_width_ff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg_width_ff;
      end
      h_eff     = (cfg_height_ff == '0) ? ROW_W'(1) : cfg_height_ff;
      r_eff     = RAD_W'((cfg_radius_ff > MAX_RADIUS) ? MAX_RADIUS : cfg_radius_ff);
      span_m1   = TAP_W'({r_eff, 1'b0});
      lag       = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);
      pend_plus = pend_ff + PEND_W'(1);

      in_col_last  = (WIDTH_W'(in_col_ff) + WIDTH_W'(1)) >= w_eff;
      in_row_last  = ((ROW_W+1)'(in_row_ff) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
      out_col_last = (WIDTH_W'(out_col_ff) + WIDTH_W'(1)) >= w_eff;
      out_row_last = ((ROW_W+1)'(out_row_ff) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
      out_border   = out_row_ff < ROW_W'(r_eff) || out_col_ff < COL_W'(r_eff) ||
                     ((ROW_W+1)'(out_row_ff) + (ROW_W+1)'(r_eff)) >= (ROW_W+1)'(h_eff) ||
                     ((WIDTH_W+1)'(out_col_ff) + (WIDTH_W+1)'(r_eff)) >=
                        (WIDTH_W+1)'(w_eff);
      center_mux   = lane_res[job_slot_ff].line_q;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      in_slot_in    = in_slot_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_slot_in   = out_slot_ff;
      pend_in       = pend_ff;
      job_col_in    = job_col_ff;
      job_slot_in   = job_slot_ff;
      job_border_in = job_border_ff;
      job_fend_in   = job_fend_ff;
      center_in     = center_ff;
      tap_in        = tap_ff;
      drain_in      = drain_ff;
      res_in        = res_ff;
      do_emit       = 1'b0;
      load_rsp      = 1'b0;
      merge_start   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_PIXEL: begin
                     // Advance the write position; a result is due once the
                     // window of the oldest pending pixel is complete.
                     if (in_col_last) begin
                        in_col_in  = '0;
                        in_slot_in = (in_slot_ff == SLOT_W'(NLINES - 1)) ?
                                     '0 : in_slot_ff + SLOT_W'(1);
                        in_row_in  = in_row_last ? '0 : in_row_ff + ROW_W'(1);
                     end else begin
                        in_col_in = in_col_ff + COL_W'(1);
                     end
                     if (LAG_W'(pend_plus) > lag) begin
                        do_emit = 1'b1;
                     end else begin
                        pend_in = pend_plus;
                     end
                  end
                  FUNC_FLUSH: begin
                     // Drain only after a finished frame.
                     if (pend_ff != '0 && in_row_ff == '0 && in_col_ff == '0) begin
                        do_emit = 1'b1;
                        pend_in = pend_ff - PEND_W'(1);
                     end
                  end
                  default: ;
               endcase
               if (do_emit) begin
                  job_col_in    = out_col_ff;
                  job_slot_in   = out_slot_ff;
                  job_border_in = out_border;
                  job_fend_in   = out_row_last && out_col_last;
                  if (out_col_last) begin
                     out_col_in  = '0;
                     out_slot_in = (out_slot_ff == SLOT_W'(NLINES - 1)) ?
                                   '0 : out_slot_ff + SLOT_W'(1);
                     out_row_in  = out_row_last ? '0 : out_row_ff + ROW_W'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_W'(1);
                  end
                  state_in = ST_CENTER;
               end
            end
         end
         ST_CENTER: begin
            state_in = ST_CWAIT;
         end
         ST_CWAIT: begin
            center_in = center_mux;
            if (job_border_ff) begin
               // Border pixels are copied; gray mode zeroes the upper channels.
               for (int c = 0; c < NCH; c++) begin
                  res_in[c] = (cfg_gray_ff && c != 0) ? '0 : center_mux[c*CH_W +: CH_W];
               end
               state_in = ST_FINISH;
            end else begin
               tap_in   = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (tap_ff == span_m1) begin
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_ff == DRAIN_W'(PIPE_DEPTH - 1)) begin
               merge_start = 1'b1;
               state_in    = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (merge_res.done) begin
               // A zero weight sum falls back to the center pixel.
               for (int c = 0; c < NCH; c++) begin
                  if (cfg_gray_ff && c != 0) begin
                     res_in[c] = '0;
                  end else if (merge_res.wzero[c]) begin
                     res_in[c] = center_ff[c*CH_W +: CH_W];
                  end else begin
                     res_in[c] = merge_res.quot[c];
                  end
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tap_ff       <= '0;
         drain_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
         drain_ff     <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      job_col_ff    <= job_col_in;
      job_slot_ff   <= job_slot_in;
      job_border_ff <= job_border_in;
      job_fend_ff   <= job_fend_in;
      center_ff     <= center_in;
      res_ff        <= res_in;
      if (load_rsp) begin
         rsp_ch_ff     <= res_ff;
         rsp_border_ff <= job_border_ff;
         rsp_fend_ff   <= job_fend_ff;
      end
   end

   // Lane control: pixel and weight writes happen in the accepting cycle; the
   // read column is the center column until the sweep walks the window.
   always_comb begin
      lane_ctrl.pix_we      = accept && req_func == FUNC_PIXEL;
      lane_ctrl.pix_slot    = in_slot_ff;
      lane_ctrl.pix_col     = in_col_ff;
      lane_ctrl.pix_data    = {req_pixel_ch2, req_pixel_ch1, req_pixel_ch0};
      lane_ctrl.rng_we      = accept && req_func == FUNC_RANGE;
      lane_ctrl.spa_we      = accept && req_func == FUNC_SPATIAL;
      lane_ctrl.w_idx       = req_weight_index;
      lane_ctrl.w_val       = req_weight_value[WEIGHT_BITS-1:0];
      lane_ctrl.step_valid  = (state_ff == ST_SWEEP);
      lane_ctrl.step_tap    = tap_ff;
      lane_ctrl.acc_clear   = (state_ff == ST_CENTER);
      lane_ctrl.job_slot    = job_slot_ff;
      lane_ctrl.radius      = r_eff;
      lane_ctrl.weight_mode = cfg_mode_ff;
      lane_ctrl.center      = center_ff;
      if (state_ff == ST_SWEEP) begin
         lane_ctrl.rd_col = job_col_ff - COL_W'(r_eff) + COL_W'(tap_ff);
      end else begin
         lane_ctrl.rd_col = job_col_ff;
      end
   end

   for (genvar g = 0; g < NLINES; g++) begin : g_lane
      bif_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .lane_id (SLOT_W'(g)),
         .ctrl    (lane_ctrl),
         .result  (lane_res[g])
      );
   end

   bif_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .start    (merge_start),
      .lane_res (lane_res),
      .result   (merge_res)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_ch0   = rsp_ch_ff[0];
   assign rsp_out_ch1   = rsp_ch_ff[1];
   assign rsp_out_ch2   = rsp_ch_ff[2];
   assign rsp_is_border = rsp_border_ff;
   assign rsp_frame_end = rsp_fend_ff;

endmodule
`default_nettype wire
